### hdl/sha256_pkg.sv
// Package with SHA-256 types, constants and a rotate-right helper function.
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_START,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } ctrl_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       wr_byte;
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic       count_byte;
        logic       load_word;
        logic [3:0] load_idx;
        logic       start_rounds;
        logic       round_step;
        logic [5:0] round_idx;
        logic       add_chain;
        logic       reset_chain;
        logic       shift_out;
    } dp_cmd_t;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam int         LEN_OFFSET = 56;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

endpackage
`default_nettype wire

### hdl/sha256_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module sha256_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/sha256_datapath.sv
// SHA-256 datapath: block buffer, schedule window, round unit, chain words, length.
`default_nettype none
module sha256_datapath
    import sha256_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire dp_cmd_t cmd,
    output logic [63:0]  message_bits,
    output logic [31:0]  out_word
);
    logic [63:0] bits_reg;
    logic [31:0] chain_reg [8];
    logic [31:0] work_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] word_reg;
    logic [5:0]  raddr;
    logic [7:0]  rdata;

    // Byte reads: four bytes per schedule word, two address bits from a counter.
    logic [1:0]  byte_cnt_reg;
    logic        rd_pend_reg;
    logic        rd_last_reg;   // byte now on rdata completes a word

    assign raddr = {cmd.load_idx, byte_cnt_reg};

    sha256_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
        .clk  (clk),
        .we   (cmd.wr_byte),
        .waddr(cmd.wr_addr),
        .wdata(cmd.wr_data),
        .raddr(raddr),
        .rdata(rdata)
    );

    // Message word for this round and new schedule word.
    logic [31:0] wt, s0, s1, w_new;
    logic [31:0] t1, t2, big0, big1, ch, maj;

    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        wt = w_reg[0];
        big1 = rotr(work_reg[4], 6) ^ rotr(work_reg[4], 11) ^ rotr(work_reg[4], 25);
        ch = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        t1 = work_reg[7] + big1 + ch + ROUND_K[cmd.round_idx] + wt;
        big0 = rotr(work_reg[0], 2) ^ rotr(work_reg[0], 13) ^ rotr(work_reg[0], 22);
        maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
            ^ (work_reg[1] & work_reg[2]);
        t2 = big0 + maj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
            byte_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.reset_chain)
            begin
                bits_reg <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= INIT_HASH[i];
                end
            end
            else
            begin
                if (cmd.count_byte)
                begin
                    bits_reg <= bits_reg + 64'd8;
                end
                if (cmd.add_chain)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                end
                if (cmd.shift_out)
                begin
                    for (int i = 0; i < 7; i++)
                    begin
                        chain_reg[i] <= chain_reg[i + 1];
                    end
                    chain_reg[7] <= chain_reg[0];
                end
            end
            if (cmd.load_word)
            begin
                byte_cnt_reg <= byte_cnt_reg + 2'd1;
                rd_pend_reg  <= 1'b1;
                rd_last_reg  <= (byte_cnt_reg == 2'd3);
            end
            else
            begin
                byte_cnt_reg <= '0;
                rd_pend_reg  <= 1'b0;
                rd_last_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            word_reg <= {word_reg[23:0], rdata};
        end
        // A completed word shifts into the top of the window.
        if (rd_last_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= {word_reg[23:0], rdata};
        end
        else if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end
        if (cmd.start_rounds)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round_step)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    assign message_bits = bits_reg;
    assign out_word     = chain_reg[0];
endmodule
`default_nettype wire

### hdl/sha256_ctrl.sv
// SHA-256 controller: byte intake, padding, block sequencing and digest output.
`default_nettype none
module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_item_t  in_data,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic [2:0]     out_index,
    input  wire logic [63:0] message_bits,
    output dp_cmd_t        cmd
);
    ctrl_state_t state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic [5:0] cnt_reg, cnt_next;       // pad address, load address or round
    logic [5:0] mark_reg, mark_next;     // where the pad mark goes
    logic       second_reg, second_next; // pad pass of a block that holds only the length
    logic       final_reg, final_next;   // block being hashed is the length block
    logic       last_reg, last_next;     // a pad pass follows this block
    logic [2:0] idx_reg, idx_next;
    logic       in_fire;
    logic       len_block;
    logic [2:0] len_byte;

    assign in_fire   = in_valid && in_ready;
    assign len_block = second_reg || (mark_reg < 6'(LEN_OFFSET));
    assign len_byte  = cnt_reg[2:0];

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        cnt_next    = cnt_reg;
        mark_next   = mark_reg;
        second_next = second_reg;
        final_next  = final_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.byte_valid)
                    begin
                        fill_next = fill_reg + 6'd1;
                    end
                    if (in_data.byte_valid && fill_reg == 6'd63)
                    begin
                        // A full block is hashed first; padding follows if the message ended.
                        last_next   = in_data.last_byte;
                        final_next  = 1'b0;
                        mark_next   = '0;
                        second_next = 1'b0;
                        cnt_next    = '0;
                        state_next  = ST_LOAD;
                    end
                    else if (in_data.last_byte)
                    begin
                        mark_next   = fill_reg + {5'd0, in_data.byte_valid};
                        second_next = 1'b0;
                        fill_next   = '0;
                        cnt_next    = '0;
                        state_next  = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    final_next  = len_block;
                    last_next   = !len_block;
                    second_next = !len_block;
                    cnt_next    = '0;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    cnt_next   = '0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cnt_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    cnt_next   = '0;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (final_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else if (last_reg)
                begin
                    cnt_next   = '0;
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
                final_next = 1'b0;
                last_next  = 1'b0;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            cnt_reg    <= '0;
            mark_reg   <= '0;
            second_reg <= 1'b0;
            final_reg  <= 1'b0;
            last_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            cnt_reg    <= cnt_next;
            mark_reg   <= mark_next;
            second_reg <= second_next;
            final_reg  <= final_next;
            last_reg   <= last_next;
            idx_reg    <= idx_next;
        end
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_EMIT);
        out_index = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_byte    = in_fire && in_data.byte_valid;
                cmd.wr_addr    = fill_reg;
                cmd.wr_data    = in_data.data_byte;
                cmd.count_byte = in_fire && in_data.byte_valid;
            end
            ST_PAD:
            begin
                // Message bytes below the mark stay; the length block gets the count last.
                cmd.wr_addr = cnt_reg;
                cmd.wr_byte = second_reg || (cnt_reg >= mark_reg);
                if (!second_reg && cnt_reg == mark_reg)
                begin
                    cmd.wr_data = PAD_MARK;
                end
                else if (len_block && cnt_reg >= 6'(LEN_OFFSET))
                begin
                    cmd.wr_data = message_bits[{3'd7 - len_byte, 3'b000} +: 8];
                end
                else
                begin
                    cmd.wr_data = 8'h00;
                end
            end
            ST_LOAD:
            begin
                cmd.load_word = 1'b1;
                cmd.load_idx  = cnt_reg[5:2];
            end
            ST_START:
            begin
                cmd.start_rounds = 1'b1;
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                cmd.round_idx  = cnt_reg;
            end
            ST_ADD:
            begin
                cmd.add_chain = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.shift_out   = out_ready;
                cmd.reset_chain = out_ready && (idx_reg == 3'd7);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule
`default_nettype wire

### hdl/sha256_stream_hasher_core.sv
// Top level of the SHA-256 streaming hasher.
// Usage:
//   Input channel in_valid/in_ready carries one byte per transfer with flags
//   byte_valid and last_byte. Bytes fill a 64-byte buffer; each full block is
//   hashed while in_ready is low.
//   A full block holds in_ready low while the block runs buffer reads, a
//   setup step, the rounds and a final add, in turn through the single round
//   unit and the byte-wide buffer read port.
//   On last_byte the block pads (one or two padded blocks), compresses, then
//   offers eight digest words on out_valid/out_ready, word_index 0 first,
//   last_word on the eighth; words go out one per cycle while out_ready is high.
//   While the receiver stalls, the current word holds and no input is taken.
//   After the eighth word transfers, the chaining words and length counter
//   return to their initial values and input resumes on the next cycle.
//   Reset (rst_n low) returns the block to idle with the initial hash values.
`default_nettype none
module sha256_stream_hasher_core
    import sha256_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_item_t  in_data,
    input  wire logic      in_valid,
    output logic           in_ready,
    output out_item_t      out_data,
    output logic           out_valid,
    input  wire logic      out_ready
);
    dp_cmd_t     cmd;
    logic [63:0] message_bits;
    logic [31:0] out_word;
    logic [2:0]  out_index;

    sha256_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_index   (out_index),
        .message_bits(message_bits),
        .cmd         (cmd)
    );

    sha256_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .message_bits(message_bits),
        .out_word    (out_word)
    );

    assign out_data.digest_word = out_word;
    assign out_data.word_index  = out_index;
    assign out_data.last_word   = (out_index == 3'd7);
endmodule
`default_nettype wire
